@@ rtl/dcbf_pkg.sv @@
// shared types, constants, coefficient table and sequencer program for the dc-blocked fir
`timescale 1ns / 1ps

package dcbf_pkg;

    localparam int Q_SHIFT    = 10;
    localparam int POLE_W     = 10;
    localparam logic [POLE_W-1:0] POLE_RESET = 10'd1022;
    localparam int OUT_W      = 21;
    localparam int OUT_DATA_W = 24;
    localparam int COEF_W     = 11;
    localparam int COEF_COUNT = 36;
    localparam int COEF_IW    = 6;

    // half of the symmetric low-pass, outermost tap first, centre tap last
    localparam logic signed [COEF_W-1:0] COEF_HALF [COEF_COUNT] = '{
        11'sd0,   11'sd2,   11'sd2,  -11'sd2,   11'sd0,   11'sd2,  -11'sd1,  -11'sd2,
        11'sd3,   11'sd0,  -11'sd4,   11'sd4,   11'sd3,  -11'sd7,   11'sd2,   11'sd7,
       -11'sd8,  -11'sd3,   11'sd12, -11'sd6,  -11'sd10,  11'sd16,  11'sd0,  -11'sd21,
        11'sd16,  11'sd13, -11'sd32,  11'sd8,   11'sd36, -11'sd42, -11'sd15,  11'sd79,
       -11'sd49, -11'sd108, 11'sd304, 11'sd631
    };

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_BMUL   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_BADD   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ISSUE  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DRAIN2 = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FINISH = 3'd6;

    // jump conditions: move on to nxt when the condition holds, else stay
    localparam int COND_W = 2;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 2'd0;
    localparam logic [COND_W-1:0] COND_IN_VALID = 2'd1;
    localparam logic [COND_W-1:0] COND_LAST     = 2'd2;
    localparam logic [COND_W-1:0] COND_OUT_FREE = 2'd3;

    typedef struct packed {
        logic              accept;
        logic              blk_mul;
        logic              blk_add;
        logic              issue;
        logic              finish;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] nxt;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        w.cond = COND_ALWAYS;
        unique case (step)
            STEP_WAIT:
            begin
                w.accept = 1'b1;
                w.cond   = COND_IN_VALID;
                w.nxt    = STEP_BMUL;
            end
            STEP_BMUL:
            begin
                w.blk_mul = 1'b1;
                w.nxt     = STEP_BADD;
            end
            STEP_BADD:
            begin
                w.blk_add = 1'b1;
                w.nxt     = STEP_ISSUE;
            end
            STEP_ISSUE:
            begin
                w.issue = 1'b1;
                w.cond  = COND_LAST;
                w.nxt   = STEP_DRAIN1;
            end
            STEP_DRAIN1:
            begin
                w.nxt = STEP_DRAIN2;
            end
            STEP_DRAIN2:
            begin
                w.nxt = STEP_FINISH;
            end
            STEP_FINISH:
            begin
                w.finish = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.nxt    = STEP_WAIT;
            end
            default:
            begin
                w.nxt = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    // coefficient by table position, zero outside the table
    function automatic logic signed [COEF_W-1:0] coef_at(input int k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (k >= 0 && k < COEF_COUNT)
        begin
            c = COEF_HALF[k[COEF_IW-1:0]];
        end
        return c;
    endfunction

endpackage

@@ rtl/dc_blocked_lowpass_fir_unit.sv @@
// dc blocker followed by a folded symmetric fir low-pass, run by a microcoded sequencer
//
// One sample in, one filtered sample out. A short program in a read-only table steps a
// small datapath: the blocker does the pole multiply, then the add and saturate, then one
// shared multiply-accumulate handles one folded tap pair per cycle, reading both taps of
// the pair from a dual-read delay-line ram. The next sample is taken only once the result
// of the last one is stored, so the pair loop through the shared multiplier sets the rate
// of items. A result waits in an output register while the next sample is taken, and the
// final step holds only if that register is still full. The delay line needs no clearing
// pass: a fill count makes taps never written read as zero.
`timescale 1ns / 1ps

module dc_blocked_lowpass_fir_unit #(
    parameter int TAPS        = 71,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: pole_coefficient
    input  logic                                cfg_wr_en,
    input  logic [dcbf_pkg::POLE_W-1:0]         cfg_wr_data,
    // input stream, tdata: sample
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    // output stream, tdata: filtered
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dcbf_pkg::OUT_DATA_W-1:0]     m_tdata
);

    import dcbf_pkg::*;

    localparam int BLK_W    = SAMPLE_BITS + 2;
    localparam int DEPTH    = TAPS - 1;
    localparam int AW       = $clog2(DEPTH);
    localparam int PAIRS    = (TAPS + 1) / 2;
    localparam int PW       = $clog2(PAIRS);
    localparam int WIN_W    = $clog2(TAPS);
    localparam int CW       = WIN_W + 1;
    localparam int FW       = $clog2(DEPTH + 1);
    localparam int CENTRE   = (TAPS - 1) / 2;
    localparam int KOFF     = COEF_COUNT - 1 - CENTRE;
    localparam int PB_W     = BLK_W + POLE_W + 1;
    localparam int PROD_W   = COEF_W + BLK_W + 1;
    localparam int TERM_W   = PROD_W - Q_SHIFT;
    localparam int ACC_RAW  = TERM_W + WIN_W;
    localparam int ACC_W    = (ACC_RAW > OUT_W) ? ACC_RAW : OUT_W + 1;
    localparam logic signed [BLK_W+1:0] BLK_HI = (BLK_W+2)'((1 << (BLK_W - 1)) - 1);
    localparam logic signed [BLK_W+1:0] BLK_LO = -BLK_HI - (BLK_W+2)'(1);
    localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI - ACC_W'(1);

    // sequencer
    logic [STEP_W-1:0] step_reg;
    ctrl_t             ctrl;
    logic              cond_ok;

    // configuration and blocker state
    logic        [POLE_W-1:0]      pole_reg;
    logic signed [SAMPLE_BITS-1:0] last_sample_reg;
    logic signed [BLK_W-1:0]       last_blocked_reg;
    logic signed [SAMPLE_BITS:0]   diff_reg;
    logic signed [PB_W-1:0]        blk_prod_reg;
    logic signed [BLK_W-1:0]       blocked_reg;
    logic signed [BLK_W-1:0]       blocked_next;
    logic signed [BLK_W:0]         fb;
    logic signed [BLK_W+1:0]       blk_sum;
    logic signed [SAMPLE_BITS-1:0] sample;

    // delay line bookkeeping
    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [PW-1:0] pair_reg;
    logic [CW-1:0] win_a;
    logic [CW-1:0] win_b;
    logic [CW-1:0] head_ext;
    logic [CW-1:0] addr_a_full;
    logic [CW-1:0] addr_b_full;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [BLK_W-1:0] rd_data_a;
    logic [BLK_W-1:0] rd_data_b;
    logic          ram_we;

    // mac pipeline
    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s1_single_reg;
    logic                     s1_va_reg;
    logic                     s1_vb_reg;
    logic signed [COEF_W-1:0] s1_coef_reg;
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] mac_prod_reg;
    logic signed [BLK_W-1:0]  a_val;
    logic signed [BLK_W-1:0]  b_val;
    logic signed [BLK_W:0]    pair_sum;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [OUT_W-1:0]  acc_sat;

    // output register
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_data_reg;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_IN_VALID: cond_ok = s_tvalid;
            COND_LAST:     cond_ok = (pair_reg == PW'(PAIRS - 1));
            COND_OUT_FREE: cond_ok = !out_valid_reg || m_tready;
            default:       cond_ok = 1'b1;
        endcase
    end

    assign s_tready = ctrl.accept;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign ram_we   = ctrl.finish && cond_ok;

    // blocker add and saturate
    assign fb      = blk_prod_reg[PB_W-1:Q_SHIFT];
    assign blk_sum = (BLK_W+2)'(fb) + (BLK_W+2)'(diff_reg);

    always_comb
    begin
        priority if (blk_sum > BLK_HI)
        begin
            blocked_next = BLK_HI[BLK_W-1:0];
        end
        else if (blk_sum < BLK_LO)
        begin
            blocked_next = BLK_LO[BLK_W-1:0];
        end
        else
        begin
            blocked_next = blk_sum[BLK_W-1:0];
        end
    end

    // tap i sits at head - i in the circular buffer, mirror tap at head - (TAPS-1-i)
    assign win_a    = CW'(pair_reg);
    assign win_b    = CW'(TAPS - 1) - win_a;
    assign head_ext = CW'(head_reg);
    assign addr_a_full = (win_a > head_ext) ? head_ext + CW'(DEPTH) - win_a : head_ext - win_a;
    assign addr_b_full = (win_b > head_ext) ? head_ext + CW'(DEPTH) - win_b : head_ext - win_b;
    assign rd_addr_a   = addr_a_full[AW-1:0];
    assign rd_addr_b   = addr_b_full[AW-1:0];

    dcbf_ram #(
        .WIDTH (BLK_W),
        .DEPTH (DEPTH)
    ) u_delay_ram (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (head_reg),
        .wr_data   (blocked_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // newest tap comes from the blocker, taps not yet written read as zero
    assign a_val = s1_first_reg ? blocked_reg : (s1_va_reg ? $signed(rd_data_a) : '0);
    assign b_val = (s1_single_reg || !s1_vb_reg) ? '0 : $signed(rd_data_b);
    assign pair_sum = (BLK_W+1)'(a_val) + (BLK_W+1)'(b_val);
    assign term     = mac_prod_reg[PROD_W-1:Q_SHIFT];

    always_comb
    begin
        priority if (acc_reg > OUT_HI)
        begin
            acc_sat = OUT_HI[OUT_W-1:0];
        end
        else if (acc_reg < OUT_LO)
        begin
            acc_sat = OUT_LO[OUT_W-1:0];
        end
        else
        begin
            acc_sat = acc_reg[OUT_W-1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_WAIT;
            pole_reg         <= POLE_RESET;
            last_sample_reg  <= '0;
            last_blocked_reg <= '0;
            head_reg         <= '0;
            fill_reg         <= '0;
            pair_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cond_ok)
            begin
                step_reg <= ctrl.nxt;
            end
            if (cfg_wr_en)
            begin
                pole_reg <= cfg_wr_data;
            end
            if (ctrl.accept && s_tvalid)
            begin
                last_sample_reg <= sample;
            end
            if (ctrl.blk_mul)
            begin
                pair_reg <= '0;
            end
            else if (ctrl.issue && !cond_ok)
            begin
                pair_reg <= pair_reg + PW'(1);
            end
            s1_valid_reg <= ctrl.issue;
            s2_valid_reg <= s1_valid_reg;
            if (ram_we)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                last_blocked_reg <= blocked_reg;
                head_reg         <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                if (fill_reg != FW'(DEPTH))
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.accept && s_tvalid)
        begin
            diff_reg <= (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(last_sample_reg);
        end
        if (ctrl.blk_mul)
        begin
            blk_prod_reg <= $signed({1'b0, pole_reg}) * last_blocked_reg;
            acc_reg      <= '0;
        end
        if (ctrl.blk_add)
        begin
            blocked_reg <= blocked_next;
        end
        if (ctrl.issue)
        begin
            s1_first_reg  <= (pair_reg == '0);
            s1_single_reg <= (win_a == win_b);
            s1_va_reg     <= (win_a <= CW'(fill_reg));
            s1_vb_reg     <= (win_b <= CW'(fill_reg));
            s1_coef_reg   <= coef_at(KOFF + int'(pair_reg));
        end
        if (s1_valid_reg)
        begin
            mac_prod_reg <= s1_coef_reg * pair_sum;
        end
        if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
        if (ram_we)
        begin
            out_data_reg <= acc_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_W){1'b0}}, out_data_reg};

    // the mac pipeline is empty whenever a new sample can be taken or a result is stored
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("mac pipeline busy while taking a sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("result stored before the accumulation drained");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FW'(DEPTH)) && (head_reg <= AW'(DEPTH - 1)))
        else $error("delay line pointer or fill count out of range");

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> ($stable(out_data_reg) && out_valid_reg))
        else $error("pending result lost");

endmodule

@@ rtl/dcbf_ram.sv @@
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module dcbf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 70
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
